@@ sv/btc_pkg.sv @@
// -----------------------------------------------------------------------------
// btc_pkg
// Shared types, constants and table helpers for the bigram table cipher.
// -----------------------------------------------------------------------------
package btc_pkg;

   localparam int unsigned NLET   = 33;
   localparam int unsigned NCELL  = 32;
   localparam int unsigned LW     = 6;
   localparam int unsigned CW     = 5;
   localparam logic [LW-1:0] FILLER_RESET = 6'd22;

   localparam logic [1:0] FN_KEY_LETTER = 2'd0;
   localparam logic [1:0] FN_KEY_DONE   = 2'd1;
   localparam logic [1:0] FN_TEXT       = 2'd2;
   localparam logic [1:0] FN_TEXT_END   = 2'd3;

   localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
   localparam logic [1:0] REG_DIRECTION  = 2'd1;
   localparam logic [1:0] REG_FILLER     = 2'd2;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_WALK  = 8'b0000_0010,
      ST_RD_A  = 8'b0000_0100,
      ST_RD_B  = 8'b0000_1000,
      ST_RD_T1 = 8'b0001_0000,
      ST_RD_T2 = 8'b0010_0000,
      ST_POST  = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic [CW-1:0] cell_a;
      logic [CW-1:0] cell_b;
   } pair_cells_type;

   function automatic logic [LW-1:0] normalize(input logic size, input logic [LW-1:0] x);
      logic [LW-1:0] r;
      r = x;
      if (x == 6'd6) r = 6'd5;
      else if (!size && x == 6'd10) r = 6'd9;
      else if (!size && x == 6'd27) r = 6'd29;
      return r;
   endfunction

   function automatic logic [LW-1:0] walk_letter(input logic size, input logic [CW-1:0] i);
      logic [LW-1:0] r;
      logic [LW-1:0] iw;
      iw = {1'b0, i};
      if (size) begin
         r = (i < 5'd6) ? iw : iw + 6'd1;
      end else begin
         if (i < 5'd6) r = iw;
         else if (i < 5'd9) r = iw + 6'd1;
         else if (i < 5'd25) r = iw + 6'd2;
         else if (i == 5'd25) r = 6'd29;
         else if (i == 5'd26) r = 6'd28;
         else r = iw + 6'd3;
      end
      return r;
   endfunction

   function automatic logic [LW-1:0] n_cells(input logic size);
      return size ? 6'd32 : 6'd30;
   endfunction

endpackage

@@ sv/bigram_table_cipher_cyrillic.sv @@
// -----------------------------------------------------------------------------
// bigram_table_cipher_cyrillic
// Bigram table cipher over Cyrillic letter codes, 5x6 or 4x8 key table.
// -----------------------------------------------------------------------------
//  channel | direction | payload
//  req_    | in        | tuser = func, tdata[5:0] = letter
//  rsp_    | out       | tdata[5:0] = out_letter, tlast = last
//  csr_    | in        | write enable, register index, data
//
//  Key letter: placed when taken. Key done: the table cells (30 or 32) are
//  walked to place the rest. Text pair: RD_A, RD_B, RD_T1, RD_T2, POST on two
//  memories, then one result transaction per cycle while rsp_tready is high.
//  Reset is synchronous; it clears placement marks, counters and text state.
//  A stalled result holds the block; no new transaction is taken meanwhile.
// -----------------------------------------------------------------------------
module bigram_table_cipher_cyrillic
   import btc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [5:0] letter, [7:6] zero
   input  logic [1:0]    req_tuser,   // [1:0] func
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,   // [5:0] out_letter, [7:6] zero
   output logic          rsp_tlast,
   input  logic          csr_we,
   input  logic [1:0]    csr_addr,
   input  logic [5:0]    csr_wdata
);

   logic [LW-1:0] letter_at_cell [NCELL];
   logic [CW-1:0] cell_of_letter [NLET];

   state_type     state_ff, state_in;
   logic          size_ff, size_in, dir_ff, dir_in;
   logic [LW-1:0] filler_ff, filler_in;
   logic [NLET-1:0] placed_ff, placed_in;
   logic [LW-1:0] fill_ff, fill_in;
   logic          ready_ff, ready_in;
   logic [LW-1:0] pend_ff, pend_in, held_ff, held_in, bh_ff, bh_in;
   logic          pendv_ff, pendv_in, heldv_ff, heldv_in, bhv_ff, bhv_in;
   logic [LW-1:0] a_ff, a_in, b_ff, b_in, ra_ff, ra_in;
   logic [CW-1:0] ca_ff, ca_in, t2_ff, t2_in, walk_ff, walk_in;
   logic          same_ff, same_in, end_ff, end_in, pass_ff, pass_in;
   logic [LW-1:0] out0_ff, out0_in, out1_ff, out1_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          sel_ff, sel_in;

   logic [CW-1:0] cell_rd_ff;
   logic [LW-1:0] let_rd_ff;
   logic [LW-1:0] cell_raddr;
   logic [CW-1:0] let_raddr;

   logic          place_en, place_ok;
   logic [LW-1:0] place_x, place_fill;
   logic [NLET-1:0] place_base;
   logic [63:0]   placed_ext;
   logic [63:0]   base_ext;
   logic          ok_a, ok_b;
   logic [LW-1:0] x_in, xn, fx, rb;
   logic [1:0]    n;
   logic [LW-1:0] o0, o1;
   pair_cells_type tgt;

   btc_pair_calc u_calc (
      .size   (size_ff),
      .enc    (!dir_ff),
      .cell_a (ca_ff),
      .cell_b (cell_rd_ff),
      .cells  (tgt)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {2'b00, sel_ff ? out1_ff : out0_ff};
   assign rsp_tlast  = sel_ff || (cnt_ff == 2'd1);
   assign x_in       = req_tdata[5:0];
   assign placed_ext = {{(64-NLET){1'b0}}, placed_ff};
   assign base_ext   = {{(64-NLET){1'b0}}, place_base};
   assign ok_a = (a_ff < 6'(NLET)) && placed_ext[a_ff] && ({1'b0, ca_ff} < n_cells(size_ff));
   assign ok_b = (b_ff < 6'(NLET)) && placed_ext[b_ff]
                 && ({1'b0, cell_rd_ff} < n_cells(size_ff));
   assign cell_raddr = (state_ff == ST_RD_A) ? a_ff : b_ff;
   assign let_raddr  = (state_ff == ST_RD_T1) ? tgt.cell_a : t2_ff;
   assign place_ok   = place_en && (place_x < 6'(NLET)) && !base_ext[place_x]
                       && (place_fill < n_cells(size_ff));

   always_ff @(posedge clock) begin
      if (place_ok) begin
         letter_at_cell[place_fill[CW-1:0]] <= place_x;
         cell_of_letter[place_x] <= place_fill[CW-1:0];
      end
      cell_rd_ff <= cell_of_letter[cell_raddr];
      let_rd_ff  <= letter_at_cell[let_raddr];
   end

   always_comb begin
      state_in = state_ff;
      size_in = size_ff; dir_in = dir_ff; filler_in = filler_ff;
      placed_in = placed_ff; fill_in = fill_ff; ready_in = ready_ff;
      pend_in = pend_ff; pendv_in = pendv_ff;
      held_in = held_ff; heldv_in = heldv_ff; bh_in = bh_ff; bhv_in = bhv_ff;
      a_in = a_ff; b_in = b_ff; ra_in = ra_ff; ca_in = ca_ff; t2_in = t2_ff;
      walk_in = walk_ff; same_in = same_ff; end_in = end_ff; pass_in = pass_ff;
      out0_in = out0_ff; out1_in = out1_ff; cnt_in = cnt_ff; sel_in = sel_ff;
      place_en = 1'b0; place_x = '0; place_fill = fill_ff; place_base = placed_ff;
      xn = normalize(size_ff, x_in);
      fx = '0; rb = '0; n = '0; o0 = '0; o1 = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (req_tuser)
                  FN_KEY_LETTER: begin
                     if (ready_ff) begin
                        place_base = '0; place_fill = '0;
                        placed_in = '0; fill_in = '0;
                        pendv_in = 1'b0; pend_in = '0; heldv_in = 1'b0; held_in = '0;
                        bhv_in = 1'b0; bh_in = '0; ready_in = 1'b0;
                     end
                     place_en = (x_in < 6'(NLET));
                     place_x = xn;
                  end
                  FN_KEY_DONE: begin
                     walk_in = '0;
                     state_in = ST_WALK;
                  end
                  FN_TEXT: begin
                     if (ready_ff) begin
                        if (!dir_ff) begin
                           if (x_in < 6'(NLET)) begin
                              if (!pendv_ff) begin
                                 pend_in = xn; pendv_in = 1'b1;
                              end else begin
                                 a_in = pend_ff;
                                 b_in = (pend_ff == xn) ? filler_ff : xn;
                                 same_in = (pend_ff == xn);
                                 end_in = 1'b0;
                                 state_in = ST_RD_A;
                              end
                           end
                        end else if (!pendv_ff) begin
                           pend_in = x_in; pendv_in = 1'b1;
                        end else begin
                           a_in = pend_ff; b_in = x_in;
                           same_in = 1'b0; end_in = 1'b0;
                           state_in = ST_RD_A;
                        end
                     end
                  end
                  FN_TEXT_END: begin
                     if (ready_ff) begin
                        if (!dir_ff && pendv_ff) begin
                           a_in = pend_ff; b_in = filler_ff;
                           same_in = 1'b0; end_in = 1'b1;
                           state_in = ST_RD_A;
                        end else begin
                           if (dir_ff && heldv_ff && held_ff != filler_ff) begin
                              out0_in = held_ff; cnt_in = 2'd1; sel_in = 1'b0;
                              state_in = ST_EMIT;
                           end
                           pendv_in = 1'b0; pend_in = '0; heldv_in = 1'b0; held_in = '0;
                           bhv_in = 1'b0; bh_in = '0;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            place_en = 1'b1;
            place_x = walk_letter(size_ff, walk_ff);
            walk_in = walk_ff + 5'd1;
            if ({1'b0, walk_ff} == n_cells(size_ff) - 6'd1) begin
               ready_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_RD_A: state_in = ST_RD_B;
         ST_RD_B: begin
            ca_in = cell_rd_ff;
            state_in = ST_RD_T1;
         end
         ST_RD_T1: begin
            pass_in = !(ok_a && ok_b);
            t2_in = tgt.cell_b;
            state_in = ST_RD_T2;
         end
         ST_RD_T2: begin
            ra_in = let_rd_ff;
            state_in = ST_POST;
         end
         ST_POST: begin
            fx = pass_ff ? a_ff : ra_ff;
            rb = pass_ff ? b_ff : let_rd_ff;
            if (!dir_ff) begin
               n = 2'd2; o0 = fx; o1 = rb;
               if (!same_ff || end_ff) begin
                  pendv_in = 1'b0; pend_in = '0;
               end
               if (end_ff) begin
                  heldv_in = 1'b0; held_in = '0; bhv_in = 1'b0; bh_in = '0;
               end
            end else begin
               pendv_in = 1'b0; pend_in = '0;
               if (heldv_ff) begin
                  if (!(held_ff == filler_ff && bhv_ff && bh_ff == fx)) begin
                     o0 = held_ff; n = 2'd1;
                  end
               end
               if (!(fx == filler_ff && (heldv_ff && held_ff == rb))) begin
                  if (n == 2'd1) o1 = fx;
                  else o0 = fx;
                  n = n + 2'd1;
               end
               bh_in = fx; bhv_in = 1'b1;
               held_in = rb; heldv_in = 1'b1;
            end
            out0_in = o0; out1_in = o1; cnt_in = n; sel_in = 1'b0;
            state_in = (n == 2'd0) ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               if (rsp_tlast) state_in = ST_IDLE;
               else sel_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (place_ok) begin
         placed_in = place_base;
         placed_in[place_x] = 1'b1;
         fill_in = place_fill + 6'd1;
      end else if (place_en) begin
         placed_in = place_base;
         fill_in = place_fill;
      end

      if (csr_we) begin
         unique case (csr_addr)
            REG_TABLE_SIZE: begin
               size_in = csr_wdata[0];
               if (csr_wdata[0] != size_ff) begin
                  placed_in = '0; fill_in = '0; ready_in = 1'b0;
                  pendv_in = 1'b0; pend_in = '0; heldv_in = 1'b0; held_in = '0;
                  bhv_in = 1'b0; bh_in = '0;
               end
            end
            REG_DIRECTION: begin
               dir_in = csr_wdata[0];
               if (csr_wdata[0] != dir_ff) begin
                  pendv_in = 1'b0; pend_in = '0; heldv_in = 1'b0; held_in = '0;
                  bhv_in = 1'b0; bh_in = '0;
               end
            end
            REG_FILLER: filler_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         size_ff <= 1'b0; dir_ff <= 1'b0; filler_ff <= FILLER_RESET;
         placed_ff <= '0; fill_ff <= '0; ready_ff <= 1'b0;
         pend_ff <= '0; pendv_ff <= 1'b0; held_ff <= '0; heldv_ff <= 1'b0;
         bh_ff <= '0; bhv_ff <= 1'b0;
         cnt_ff <= '0; sel_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         size_ff <= size_in; dir_ff <= dir_in; filler_ff <= filler_in;
         placed_ff <= placed_in; fill_ff <= fill_in; ready_ff <= ready_in;
         pend_ff <= pend_in; pendv_ff <= pendv_in; held_ff <= held_in;
         heldv_ff <= heldv_in; bh_ff <= bh_in; bhv_ff <= bhv_in;
         cnt_ff <= cnt_in; sel_ff <= sel_in;
      end
      a_ff <= a_in; b_ff <= b_in; ra_ff <= ra_in; ca_ff <= ca_in; t2_ff <= t2_in;
      walk_ff <= walk_in; same_ff <= same_in; end_ff <= end_in; pass_ff <= pass_in;
      out0_ff <= out0_in; out1_ff <= out1_in;
   end

   assert property (@(posedge clock) disable iff (reset) !(req_tready && rsp_tvalid))
      else $error("input and result sides open together");
   assert property (@(posedge clock) disable iff (reset) fill_ff <= 6'd32)
      else $error("fill count past table end");
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid |-> (cnt_ff == 2'd1 || cnt_ff == 2'd2))
      else $error("result shown with no count");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_RD_A) |-> ready_ff)
      else $error("pair lookup before table ready");

endmodule

@@ sv/btc_pair_calc.sv @@
// -----------------------------------------------------------------------------
// btc_pair_calc
// Row, column and rectangle rules on two table cells, both key sizes.
// -----------------------------------------------------------------------------
module btc_pair_calc
   import btc_pkg::*;
(
   input  logic           size,
   input  logic           enc,
   input  logic [CW-1:0]  cell_a,
   input  logic [CW-1:0]  cell_b,
   output pair_cells_type cells
);

   logic [2:0] r1, r2, c1, c2, n1, n2, m1, m2, rmax, cmax;

   function automatic logic [2:0] row_of(input logic sz, input logic [CW-1:0] c);
      logic [2:0] r;
      if (sz) r = {1'b0, c[4:3]};
      else if (c >= 5'd24) r = 3'd4;
      else if (c >= 5'd18) r = 3'd3;
      else if (c >= 5'd12) r = 3'd2;
      else if (c >= 5'd6) r = 3'd1;
      else r = 3'd0;
      return r;
   endfunction

   function automatic logic [2:0] step(input logic e, input logic [2:0] v, input logic [2:0] mx);
      logic [2:0] r;
      if (e) r = (v == mx) ? 3'd0 : v + 3'd1;
      else r = (v == 3'd0) ? mx : v - 3'd1;
      return r;
   endfunction

   function automatic logic [CW-1:0] join_rc(input logic sz, input logic [2:0] r,
                                             input logic [2:0] c);
      logic [CW-1:0] v;
      if (sz) v = {r[1:0], c};
      else v = {r, 2'b00} + {1'b0, r, 1'b0} + {2'b00, c};
      return v;
   endfunction

   always_comb begin
      rmax = size ? 3'd3 : 3'd4;
      cmax = size ? 3'd7 : 3'd5;
      r1 = row_of(size, cell_a);
      r2 = row_of(size, cell_b);
      c1 = 3'(cell_a - join_rc(size, r1, 3'd0));
      c2 = 3'(cell_b - join_rc(size, r2, 3'd0));
      n1 = r1; n2 = r2; m1 = c1; m2 = c2;
      if (r1 == r2) begin
         m1 = step(enc, c1, cmax);
         m2 = step(enc, c2, cmax);
      end else if (c1 == c2) begin
         n1 = step(enc, r1, rmax);
         n2 = step(enc, r2, rmax);
      end else begin
         m1 = c2;
         m2 = c1;
      end
      cells.cell_a = join_rc(size, n1, m1);
      cells.cell_b = join_rc(size, n2, m2);
   end

endmodule
